/* sv/izh_pkg.sv */
package izh_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int STEP_W        = 31;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  // Operand width of the shared multiplier: a 32-bit signed value, the 31-bit
  // unsigned step or a divide operand, all carried as 33-bit signed.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 64;
  localparam int BASE_W = 38;
  localparam int SUM_W  = 40;

  // The square is clamped before the divide by 100; any larger square drives
  // the voltage derivative into saturation anyway.
  localparam int SQ_W   = 41;
  localparam logic [PROD_W-1:0] SQ_CLAMP = PROD_W'(1) << (SQ_W - 1);
  localparam int X_W    = SQ_W + 2;

  // Division by 100 in two halves, each by a reciprocal multiply that is exact
  // for dividends below 2^28.
  localparam int DIV_SPLIT   = 21;
  localparam int XH_W        = X_W - DIV_SPLIT;
  localparam int QH_W        = 16;
  localparam int RH_W        = 7;
  localparam int Y_W         = RH_W + DIV_SPLIT;
  localparam int QUAD_W      = QH_W + DIV_SPLIT;
  localparam int RECIP_SHIFT = 35;
  localparam logic [28:0] RECIP_M = 29'd343597384;
  localparam int DIVISOR     = 100;
  localparam int QUAD_OFFSET = 50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_A  = 3'd0,
    CFG_SENS_B  = 3'd1,
    CFG_RESET_C = 3'd2,
    CFG_JUMP_D  = 3'd3,
    CFG_PEAK    = 3'd4,
    CFG_BIAS    = 3'd5,
    CFG_STEP    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] rate_a;
    logic signed [DATA_W-1:0] sens_b;
    logic signed [DATA_W-1:0] reset_c;
    logic signed [DATA_W-1:0] jump_d;
    logic signed [DATA_W-1:0] peak;
    logic signed [DATA_W-1:0] bias;
    logic        [STEP_W-1:0] step;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_BASE,
    OP_BASE2,
    OP_DIV_HI,
    OP_DIV_LO,
    OP_DV,
    OP_VN,
    OP_DIFF,
    OP_DU,
    OP_UN,
    OP_COMMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_SQ,
    ST_DIV_HI,
    ST_MUL_HI,
    ST_DIV_LO,
    ST_MUL_LO,
    ST_DV,
    ST_MUL_DV,
    ST_VN,
    ST_MUL_VN,
    ST_DIFF,
    ST_MUL_DIFF,
    ST_DU,
    ST_MUL_DU,
    ST_UN,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[DATA_W-1:0];
    end
  endfunction

endpackage

/* sv/izh_in_if.sv */
interface izh_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [izh_pkg::DATA_W-1:0] synaptic_current;
  logic                             restart;

  modport source (output valid, output synaptic_current, output restart, input ready);
  modport sink (input valid, input synaptic_current, input restart, output ready);
endinterface

/* sv/izh_out_if.sv */
interface izh_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [izh_pkg::DATA_W-1:0] membrane_voltage;
  logic signed [izh_pkg::DATA_W-1:0] recovery_value;
  logic                             spike;

  modport source (output valid, output membrane_voltage, output recovery_value, output spike,
                  input ready);
  modport sink (input valid, input membrane_voltage, input recovery_value, input spike,
                output ready);
endinterface

/* sv/izhikevich_neuron_step_top.sv */
// Izhikevich neuron, one forward-Euler step per input item, in signed fixed
// point with FRAC_BITS fraction bits. Each item carries the summed synaptic
// current of one tick and yields one result: the new voltage, the new recovery
// value and a spike flag. Items are taken one at a time: the next item can be
// accepted only once the result of the last one has been committed to the
// output. The work of a normal tick is a chain of seven dependent products
// (square, two reciprocal steps of the divide by 100, and the four Euler
// products) through one shared 33x33 multiplier, each with an operand-load
// state and a multiply state. A restart item skips the products and goes
// straight to the commit state. The result stays on the output until taken,
// and a new item is accepted meanwhile, but its result is held back until
// the output is free. The user must write the configuration registers only
// while no item is in flight; the block itself does not enforce it.
module izhikevich_neuron_step_top #(
  parameter int FRAC_BITS = izh_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  izh_in_if.sink                         in_i,
  izh_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [izh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [izh_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import izh_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t stat;

  izh_cfg #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  izh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_restart_i(in_i.restart),
    .stat_i      (stat),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd)
  );

  izh_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .syn_i      (in_i.synaptic_current),
    .restart_i  (in_i.restart),
    .out_ready_i(out_o.ready),
    .stat_o     (stat),
    .out_valid_o(out_o.valid),
    .voltage_o  (out_o.membrane_voltage),
    .recovery_o (out_o.recovery_value),
    .spike_o    (out_o.spike)
  );

endmodule

/* sv/izh_cfg.sv */
module izh_cfg #(
  parameter int FRAC_BITS = izh_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [izh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [izh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output izh_pkg::cfg_t                  cfg_o
);
  import izh_pkg::*;

  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] RATE_A_RST  = DATA_W'((2 * ONE + 50) / 100);
  localparam logic signed [DATA_W-1:0] SENS_B_RST  = DATA_W'((2 * ONE + 5) / 10);
  localparam logic signed [DATA_W-1:0] RESET_C_RST = DATA_W'(-65 * ONE);
  localparam logic signed [DATA_W-1:0] JUMP_D_RST  = DATA_W'(2 * ONE);
  localparam logic signed [DATA_W-1:0] PEAK_RST    = DATA_W'(30 * ONE);
  localparam logic        [STEP_W-1:0] STEP_RST    = STEP_W'((ONE + 5) / 10);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RATE_A:  cfg_d.rate_a  = cfg_data_i;
        CFG_SENS_B:  cfg_d.sens_b  = cfg_data_i;
        CFG_RESET_C: cfg_d.reset_c = cfg_data_i;
        CFG_JUMP_D:  cfg_d.jump_d  = cfg_data_i;
        CFG_PEAK:    cfg_d.peak    = cfg_data_i;
        CFG_BIAS:    cfg_d.bias    = cfg_data_i;
        CFG_STEP:    cfg_d.step    = cfg_data_i[STEP_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_a  <= RATE_A_RST;
      cfg_q.sens_b  <= SENS_B_RST;
      cfg_q.reset_c <= RESET_C_RST;
      cfg_q.jump_d  <= JUMP_D_RST;
      cfg_q.peak    <= PEAK_RST;
      cfg_q.bias    <= '0;
      cfg_q.step    <= STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/izh_ctrl.sv */
module izh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_restart_i,
  input  izh_pkg::dp_status_t stat_i,
  output logic                in_ready_o,
  output izh_pkg::dp_cmd_t    cmd_o
);
  import izh_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_restart_i ? ST_DONE : ST_MUL_SQ;
        end
      end
      ST_MUL_SQ:   state_d = ST_DIV_HI;
      ST_DIV_HI:   state_d = ST_MUL_HI;
      ST_MUL_HI:   state_d = ST_DIV_LO;
      ST_DIV_LO:   state_d = ST_MUL_LO;
      ST_MUL_LO:   state_d = ST_DV;
      ST_DV:       state_d = ST_MUL_DV;
      ST_MUL_DV:   state_d = ST_VN;
      ST_VN:       state_d = ST_MUL_VN;
      ST_MUL_VN:   state_d = ST_DIFF;
      ST_DIFF:     state_d = ST_MUL_DIFF;
      ST_MUL_DIFF: state_d = ST_DU;
      ST_DU:       state_d = ST_MUL_DU;
      ST_MUL_DU:   state_d = ST_UN;
      ST_UN:       state_d = ST_DONE;
      ST_DONE: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Each load state, the accepting IDLE among them, loads the multiplier
  // operands; the state after it lets the product settle into its register.
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
        end
      end
      ST_MUL_SQ: cmd_o.op = OP_BASE;
      ST_DIV_HI: cmd_o.op = OP_DIV_HI;
      ST_MUL_HI: cmd_o.op = OP_BASE2;
      ST_DIV_LO: cmd_o.op = OP_DIV_LO;
      ST_DV:     cmd_o.op = OP_DV;
      ST_VN:     cmd_o.op = OP_VN;
      ST_DIFF:   cmd_o.op = OP_DIFF;
      ST_DU:     cmd_o.op = OP_DU;
      ST_UN:     cmd_o.op = OP_UN;
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_COMMIT;
        end
      end
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/izh_dp.sv */
module izh_dp #(
  parameter int FRAC_BITS = izh_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  izh_pkg::dp_cmd_t                 cmd_i,
  input  izh_pkg::cfg_t                    cfg_i,
  input  logic signed [izh_pkg::DATA_W-1:0] syn_i,
  input  logic                             restart_i,
  input  logic                             out_ready_i,
  output izh_pkg::dp_status_t              stat_o,
  output logic                             out_valid_o,
  output logic signed [izh_pkg::DATA_W-1:0] voltage_o,
  output logic signed [izh_pkg::DATA_W-1:0] recovery_o,
  output logic                             spike_o
);
  import izh_pkg::*;

  localparam longint ONE = longint'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] V_RST = DATA_W'(-65 * ONE);
  localparam logic signed [DATA_W-1:0] U_RST = DATA_W'(-13 * ONE);
  localparam logic signed [BASE_W-1:0] C140  = BASE_W'(140 * ONE);
  localparam logic        [PROD_W-1:0] RND   = PROD_W'(ONE / 2);

  logic signed [DATA_W-1:0] syn_q, syn_d;
  logic                     restart_q, restart_d;
  logic signed [MUL_W-1:0]  op_a_q, op_a_d, op_b_q, op_b_d;
  logic                     rnd_q, rnd_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [BASE_W-1:0] base_q, base_d;
  logic        [XH_W-1:0]   xh_q, xh_d;
  logic        [DIV_SPLIT-1:0] xl_q, xl_d;
  logic        [QH_W-1:0]   qh_q, qh_d;
  logic signed [DATA_W-1:0] vn_q, vn_d, un_q, un_d;
  logic signed [DATA_W-1:0] v_q, v_d, u_q, u_d;
  logic                     fired_q, fired_d;
  logic                     out_valid_q, out_valid_d;

  logic signed [2*MUL_W-1:0] mul_full;

  // Shared multiplier with an optional half-LSB rounding term folded in.
  assign mul_full = op_a_q * op_b_q;
  assign prod_d   = mul_full[PROD_W-1:0] + (rnd_q ? RND : '0);

  always_comb begin
    logic signed [PROD_W-1:0] scaled;
    logic        [PROD_W-1:0] sq;
    logic        [SQ_W-1:0]   sq_c;
    logic        [X_W-1:0]    x;
    logic        [XH_W-1:0]   rh;
    logic        [Y_W-1:0]    y;
    logic        [QUAD_W-1:0] quad;
    logic signed [SUM_W-1:0]  sum;
    logic signed [BASE_W-1:0] vx;
    logic signed [DATA_W-1:0] t;

    syn_d       = syn_q;
    restart_d   = restart_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    rnd_d       = rnd_q;
    base_d      = base_q;
    xh_d        = xh_q;
    xl_d        = xl_q;
    qh_d        = qh_q;
    vn_d        = vn_q;
    un_d        = un_q;
    v_d         = v_q;
    u_d         = u_q;
    fired_d     = fired_q;
    out_valid_d = out_valid_q && !out_ready_i;

    scaled = prod_q >>> FRAC_BITS;
    sq     = prod_q >>> FRAC_BITS;
    sq_c   = (sq >= SQ_CLAMP) ? SQ_CLAMP[SQ_W-1:0] : sq[SQ_W-1:0];
    x      = {sq_c, 2'b00} + X_W'(QUAD_OFFSET);
    // The high quotient is taken straight from the product register, in the
    // same cycle that it is stored.
    rh     = xh_q - XH_W'(DIVISOR * prod_q[RECIP_SHIFT +: QH_W]);
    y      = {rh[RH_W-1:0], xl_q};
    quad   = {qh_q, prod_q[RECIP_SHIFT +: DIV_SPLIT]};
    sum    = SUM_W'(base_q) + SUM_W'(quad);
    vx     = BASE_W'(v_q);
    t      = sat32(scaled);

    case (cmd_i.op)
      OP_ACCEPT: begin
        syn_d     = syn_i;
        restart_d = restart_i;
        op_a_d    = MUL_W'(v_q);
        op_b_d    = MUL_W'(v_q);
        rnd_d     = 1'b0;
      end
      OP_BASE: begin
        base_d = (vx <<< 2) + vx + C140 - BASE_W'(u_q);
      end
      OP_BASE2: begin
        base_d = base_q + BASE_W'(cfg_i.bias) + BASE_W'(syn_q);
      end
      OP_DIV_HI: begin
        xh_d   = x[X_W-1:DIV_SPLIT];
        xl_d   = x[DIV_SPLIT-1:0];
        op_a_d = MUL_W'(x[X_W-1:DIV_SPLIT]);
        op_b_d = MUL_W'(RECIP_M);
        rnd_d  = 1'b0;
      end
      OP_DIV_LO: begin
        qh_d   = prod_q[RECIP_SHIFT +: QH_W];
        op_a_d = MUL_W'(y);
        op_b_d = MUL_W'(RECIP_M);
        rnd_d  = 1'b0;
      end
      OP_DV: begin
        op_a_d = MUL_W'(cfg_i.step);
        op_b_d = MUL_W'(sat32(PROD_W'(sum)));
        rnd_d  = 1'b1;
      end
      OP_VN: begin
        vn_d   = sat32(PROD_W'(v_q) + PROD_W'(t));
        op_a_d = MUL_W'(cfg_i.sens_b);
        op_b_d = MUL_W'(sat32(PROD_W'(v_q) + PROD_W'(t)));
        rnd_d  = 1'b1;
      end
      OP_DIFF: begin
        op_a_d = MUL_W'(cfg_i.rate_a);
        op_b_d = MUL_W'(sat32(scaled - PROD_W'(u_q)));
        rnd_d  = 1'b1;
      end
      OP_DU: begin
        op_a_d = MUL_W'(cfg_i.step);
        op_b_d = MUL_W'(t);
        rnd_d  = 1'b1;
      end
      OP_UN: begin
        un_d = sat32(PROD_W'(u_q) + PROD_W'(t));
      end
      OP_COMMIT: begin
        out_valid_d = 1'b1;
        if (restart_q) begin
          v_d     = cfg_i.reset_c;
          fired_d = 1'b0;
        end else if (vn_q >= cfg_i.peak) begin
          v_d     = cfg_i.reset_c;
          u_d     = sat32(PROD_W'(un_q) + PROD_W'(cfg_i.jump_d));
          fired_d = 1'b1;
        end else begin
          v_d     = vn_q;
          u_d     = un_q;
          fired_d = 1'b0;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    syn_q     <= syn_d;
    restart_q <= restart_d;
    op_a_q    <= op_a_d;
    op_b_q    <= op_b_d;
    rnd_q     <= rnd_d;
    prod_q    <= prod_d;
    base_q    <= base_d;
    xh_q      <= xh_d;
    xl_q      <= xl_d;
    qh_q      <= qh_d;
    vn_q      <= vn_d;
    un_q      <= un_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= V_RST;
      u_q         <= U_RST;
      fired_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v_q         <= v_d;
      u_q         <= u_d;
      fired_q     <= fired_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The state registers double as the output register: they change only when
  // the previous result has been taken.
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign voltage_o       = v_q;
  assign recovery_o      = u_q;
  assign spike_o         = fired_q;

endmodule

/* sv/izh_checker.sv */
module izh_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             in_restart_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [izh_pkg::DATA_W-1:0] out_voltage_i,
  input logic signed [izh_pkg::DATA_W-1:0] out_recovery_i,
  input logic                             out_spike_i
);

  // A result waiting on the output keeps its values.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_voltage_i)
      && $stable(out_recovery_i) && $stable(out_spike_i))
    else $error("output item changed while stalled");

  // Items are processed one at a time, so the block is busy right after taking one.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted again while an item is in flight");

  // A restart item accepted with a free output passes through the done state to
  // the output register and never reports a spike.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_restart_i && !out_valid_i |=> ##1
      (out_valid_i && !out_spike_i))
    else $error("restart item did not give a spike-free result in time");

endmodule

bind izhikevich_neuron_step_top izh_checker u_izh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_restart_i  (in_i.restart),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_voltage_i (out_o.membrane_voltage),
  .out_recovery_i(out_o.recovery_value),
  .out_spike_i   (out_o.spike)
);
